/* sv/edltp_pkg.sv */
// ----------------------------------------------------------------------------
// Debug line table parser package
// Parse phases, result kinds, status codes and format constants shared by
// the parser core and its checker.
// ----------------------------------------------------------------------------
package edltp_pkg;

    typedef enum logic [17:0] {
        PH_HDR       = 18'h00001,
        PH_SKIP      = 18'h00002,
        PH_RADDR     = 18'h00004,
        PH_RBYTES    = 18'h00008,
        PH_ALIGN     = 18'h00010,
        PH_ALIGNSKIP = 18'h00020,
        PH_HCHECK    = 18'h00040,
        PH_HMAGIC    = 18'h00080,
        PH_HLEN      = 18'h00100,
        PH_HOFF      = 18'h00200,
        PH_HTYPE     = 18'h00400,
        PH_NLEN      = 18'h00800,
        PH_NAME      = 18'h01000,
        PH_LPAIR     = 18'h02000,
        PH_CCOUNT    = 18'h04000,
        PH_CVAL      = 18'h08000,
        PH_TAIL      = 18'h10000,
        PH_DONE      = 18'h20000
    } phase_t;

    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_POINT  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EOF      = 2'd1;
    localparam logic [1:0] ST_MAGIC    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [15:0] EXEC_MAGIC  = 16'h601A;
    localparam logic [31:0] HUNK_MARKER = 32'h0000_03F1;
    localparam logic [31:0] TYPE_HEAD   = 32'h4845_4144;
    localparam logic [31:0] TYPE_LINE   = 32'h4C49_4E45;
    localparam logic [31:0] TYPE_HCLN   = 32'h4843_4C4E;
    localparam logic [31:0] HEADER_LEN  = 32'd28;

    localparam logic [31:0] HDR_POS_MAGIC = 32'd1;
    localparam logic [31:0] HDR_POS_TEXT  = 32'd5;
    localparam logic [31:0] HDR_POS_DATA  = 32'd9;
    localparam logic [31:0] HDR_POS_SYM   = 32'd17;
    localparam logic [31:0] HDR_POS_END   = 32'd27;

endpackage

/* sv/exec_debug_line_table_parser_core.sv */
// ----------------------------------------------------------------------------
// Debug line table parser core
// Walks an executable image byte by byte, skips its sections and relocation
// table, and reports filename characters, code points and a final status.
//
//   channel  | ports                  | direction
//   ---------+------------------------+----------
//   input    | s_valid/s_ready        | in
//   result   | m_valid/m_ready        | out
//   config   | cfg_wr_en/cfg_wr_data  | in
//
// Each accepted beat is parsed in the cycle it is taken and its results are
// queued in a four entry result buffer, so one beat is taken per cycle unless
// stalled. The input stalls only when fewer than two buffer entries are free.
// Reset is synchronous and active low and clears the parser state.
// ----------------------------------------------------------------------------
module exec_debug_line_table_parser_core
    import edltp_pkg::*;
#(
    parameter int FILE_INDEX_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [31:0]                cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_data_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_kind,
    output logic [FILE_INDEX_BITS-1:0] m_hunk_idx,
    output logic [7:0]                 m_name_char,
    output logic [31:0]                m_address,
    output logic [31:0]                m_line_number,
    output logic [1:0]                 m_status,
    output logic                       m_last
);

    localparam int SettleSteps = 5;

    typedef struct packed {
        phase_t                     phase;
        logic [31:0]                pos;
        logic [31:0]                fa;
        logic [2:0]                 fbs;
        logic [31:0]                skip;
        logic [31:0]                hrem;
        logic [31:0]                rpos;
        logic [31:0]                hoff;
        logic [31:0]                lacc;
        logic [31:0]                pacc;
        logic [31:0]                eleft;
        logic                       hseen;
        logic [FILE_INDEX_BITS-1:0] fcount;
        logic [1:0]                 fstat;
        logic                       hcln;
        logic [1:0]                 vstage;
        logic                       vpc;
        logic [FILE_INDEX_BITS-1:0] cfile;
    } state_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [FILE_INDEX_BITS-1:0] fidx;
        logic [7:0]                 ch;
        logic [31:0]                addr;
        logic [31:0]                line;
        logic [1:0]                 stat;
        logic                       last;
    } res_t;

    function automatic logic in_body(phase_t ph);
        in_body = (ph == PH_NLEN) || (ph == PH_NAME) || (ph == PH_LPAIR) ||
                  (ph == PH_CCOUNT) || (ph == PH_CVAL) || (ph == PH_TAIL);
    endfunction

    function automatic state_t settle_once(state_t s, logic [31:0] flen);
        state_t r;
        logic   left_lt4;
        logic   left_nz;
        r        = s;
        left_nz  = s.pos < flen;
        left_lt4 = !left_nz || ((flen - s.pos) < 32'd4);
        if (s.phase == PH_DONE) begin
            r = s;
        end else if (s.phase == PH_SKIP && s.skip == 32'd0) begin
            r.phase = PH_RADDR;
            r.fbs   = 3'd0;
        end else if (s.phase == PH_ALIGN) begin
            r.phase = (s.rpos[0] && left_nz) ? PH_ALIGNSKIP : PH_HCHECK;
        end else if (s.phase == PH_HCHECK) begin
            if (left_lt4) begin
                r.fstat = ST_OK;
                r.phase = PH_DONE;
            end else begin
                r.phase = PH_HMAGIC;
                r.fbs   = 3'd0;
            end
        end else if (s.phase == PH_NAME && s.skip == 32'd0) begin
            r.cfile  = s.fcount;
            r.fcount = s.fcount + 1'b1;
            r.fbs    = 3'd0;
            r.phase  = s.hcln ? PH_CCOUNT : PH_LPAIR;
        end else if ((s.phase == PH_HOFF || s.phase == PH_HTYPE) && s.hrem == 32'd0) begin
            r.fstat = ST_EOF;
            r.phase = PH_DONE;
        end else if (in_body(s.phase) && s.hrem == 32'd0) begin
            r.phase = PH_HCHECK;
        end else if (s.phase == PH_LPAIR && s.fbs == 3'd0 && s.hrem < 32'd8) begin
            r.phase = PH_TAIL;
        end
        settle_once = r;
    endfunction

    logic [31:0] flen_reg;
    state_t      cur_reg;
    state_t      st;
    state_t      pre;
    res_t        fifo_reg [4];
    logic [1:0]  rd_ptr_reg;
    logic [1:0]  wr_ptr_reg;
    logic [2:0]  count_reg;
    res_t        ev0;
    res_t        ev1;
    logic        ev0_v;
    logic        ev1_v;
    logic        accept;
    logic        pop;
    logic [1:0]  push_n;

    logic [31:0] fa_sh;
    logic [2:0]  fbs_inc;
    logic [31:0] room;
    logic [31:0] len4;
    logic [31:0] left;
    logic        gv_v;
    logic [31:0] gv_val;

    assign accept = s_valid && s_ready;
    assign s_ready = count_reg <= 3'd2;
    assign m_valid = count_reg != 3'd0;
    assign pop = m_valid && m_ready;

    always_comb begin
        st      = cur_reg;
        ev0     = '0;
        ev1     = '0;
        ev0_v   = 1'b0;
        ev1_v   = 1'b0;
        fa_sh   = {cur_reg.fa[23:0], s_data_byte};
        fbs_inc = cur_reg.fbs + 3'd1;
        room    = flen_reg - HEADER_LEN - cur_reg.skip;
        len4    = {cur_reg.fa[21:0], s_data_byte, 2'b00};
        left    = 32'd0;
        gv_v    = 1'b0;
        gv_val  = 32'd0;
        pre     = cur_reg;
        if (cur_reg.phase != PH_DONE && cur_reg.pos < flen_reg) begin
            st.pos = cur_reg.pos + 32'd1;
            left   = (st.pos < flen_reg) ? flen_reg - st.pos : 32'd0;
            unique case (cur_reg.phase)
                PH_HDR: begin
                    st.fa = fa_sh;
                    if (cur_reg.pos == HDR_POS_MAGIC) begin
                        if (fa_sh[15:0] != EXEC_MAGIC) st.fstat = ST_MAGIC;
                    end else if (cur_reg.pos == HDR_POS_TEXT || cur_reg.pos == HDR_POS_DATA ||
                                 cur_reg.pos == HDR_POS_SYM) begin
                        if (cur_reg.fstat == ST_OK && flen_reg >= HEADER_LEN) begin
                            if (fa_sh > room) st.fstat = ST_OVERFLOW;
                            else st.skip = cur_reg.skip + fa_sh;
                        end
                    end else if (cur_reg.pos == HDR_POS_END) begin
                        if (cur_reg.fstat != ST_OK) begin
                            st.phase   = PH_DONE;
                            ev0_v      = 1'b1;
                            ev0.kind   = KIND_STATUS;
                            ev0.stat   = cur_reg.fstat;
                        end else begin
                            st.rpos  = 32'd0;
                            st.fbs   = 3'd0;
                            st.phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: st.skip = cur_reg.skip - 32'd1;
                PH_RADDR: begin
                    st.rpos = cur_reg.rpos + 32'd1;
                    st.fa   = fa_sh;
                    st.fbs  = fbs_inc;
                    if (fbs_inc >= 3'd4) begin
                        st.fbs   = 3'd0;
                        st.phase = (fa_sh != 32'd0) ? PH_RBYTES : PH_ALIGN;
                    end
                end
                PH_RBYTES: begin
                    st.rpos = cur_reg.rpos + 32'd1;
                    if (s_data_byte == 8'd0) st.phase = PH_ALIGN;
                end
                PH_ALIGNSKIP: begin
                    st.rpos  = cur_reg.rpos + 32'd1;
                    st.phase = PH_HCHECK;
                end
                PH_HMAGIC: begin
                    st.fa  = fa_sh;
                    st.fbs = fbs_inc;
                    if (fbs_inc >= 3'd4) begin
                        st.fbs = 3'd0;
                        if (fa_sh == 32'd0 && cur_reg.hseen) begin
                            st.phase = PH_DONE;
                            ev0_v    = 1'b1;
                            ev0.kind = KIND_STATUS;
                            ev0.stat = ST_OK;
                            st.fstat = ST_OK;
                        end else if (fa_sh != HUNK_MARKER) begin
                            st.phase = PH_DONE;
                            ev0_v    = 1'b1;
                            ev0.kind = KIND_STATUS;
                            ev0.stat = ST_EOF;
                            st.fstat = ST_EOF;
                        end else begin
                            st.phase = PH_HLEN;
                        end
                    end
                end
                PH_HLEN: begin
                    st.fa  = fa_sh;
                    st.fbs = fbs_inc;
                    if (fbs_inc >= 3'd4) begin
                        st.fbs   = 3'd0;
                        st.hrem  = (len4 < left) ? len4 : left;
                        st.phase = PH_HOFF;
                    end
                end
                PH_HOFF, PH_HTYPE, PH_NLEN, PH_NAME, PH_LPAIR, PH_CCOUNT,
                PH_CVAL, PH_TAIL: begin
                    if (cur_reg.hrem != 32'd0) begin
                        st.hrem = cur_reg.hrem - 32'd1;
                        unique case (cur_reg.phase)
                            PH_HOFF: begin
                                st.fa  = fa_sh;
                                st.fbs = fbs_inc;
                                if (fbs_inc >= 3'd4) begin
                                    st.fbs   = 3'd0;
                                    st.hoff  = fa_sh;
                                    st.phase = PH_HTYPE;
                                end
                            end
                            PH_HTYPE: begin
                                st.fa  = fa_sh;
                                st.fbs = fbs_inc;
                                if (fbs_inc >= 3'd4) begin
                                    st.fbs = 3'd0;
                                    if (fa_sh == TYPE_HEAD) begin
                                        st.hseen = 1'b1;
                                        st.phase = PH_TAIL;
                                    end else if (fa_sh == TYPE_LINE) begin
                                        st.hcln  = 1'b0;
                                        st.phase = PH_NLEN;
                                    end else if (fa_sh == TYPE_HCLN) begin
                                        st.hcln  = 1'b1;
                                        st.phase = PH_NLEN;
                                    end else begin
                                        st.phase = PH_DONE;
                                        st.fstat = ST_EOF;
                                        ev0_v    = 1'b1;
                                        ev0.kind = KIND_STATUS;
                                        ev0.stat = ST_EOF;
                                    end
                                end
                            end
                            PH_NLEN: begin
                                st.fa  = fa_sh;
                                st.fbs = fbs_inc;
                                if (fbs_inc >= 3'd4) begin
                                    st.fbs = 3'd0;
                                    if (len4 > st.hrem) begin
                                        st.phase = PH_TAIL;
                                    end else begin
                                        st.skip  = len4;
                                        st.phase = PH_NAME;
                                    end
                                end
                            end
                            PH_NAME: begin
                                st.skip = cur_reg.skip - 32'd1;
                                if (s_data_byte != 8'd0) begin
                                    ev0_v    = 1'b1;
                                    ev0.kind = KIND_NAME;
                                    ev0.fidx = cur_reg.fcount;
                                    ev0.ch   = s_data_byte;
                                end
                            end
                            PH_LPAIR: begin
                                st.fa = fa_sh;
                                if (cur_reg.fbs == 3'd3) st.lacc = fa_sh;
                                if (cur_reg.fbs == 3'd7) begin
                                    st.fbs   = 3'd0;
                                    ev0_v    = 1'b1;
                                    ev0.kind = KIND_POINT;
                                    ev0.fidx = cur_reg.cfile;
                                    ev0.addr = fa_sh + cur_reg.hoff;
                                    ev0.line = st.lacc;
                                end else begin
                                    st.fbs = fbs_inc;
                                end
                            end
                            PH_CCOUNT: begin
                                st.fa  = fa_sh;
                                st.fbs = fbs_inc;
                                if (fbs_inc >= 3'd4) begin
                                    st.fbs    = 3'd0;
                                    st.eleft  = fa_sh;
                                    st.lacc   = 32'd0;
                                    st.pacc   = cur_reg.hoff;
                                    st.vstage = 2'd0;
                                    st.vpc    = 1'b0;
                                    st.phase  = (fa_sh != 32'd0) ? PH_CVAL : PH_TAIL;
                                end
                            end
                            PH_CVAL: begin
                                if (cur_reg.vstage == 2'd0) begin
                                    if (s_data_byte != 8'd0) begin
                                        gv_v   = 1'b1;
                                        gv_val = {24'd0, s_data_byte};
                                    end else begin
                                        st.vstage = 2'd1;
                                        st.fbs    = 3'd0;
                                    end
                                end else if (cur_reg.vstage == 2'd1) begin
                                    st.fa  = fa_sh;
                                    st.fbs = fbs_inc;
                                    if (fbs_inc >= 3'd2) begin
                                        st.fbs = 3'd0;
                                        if (fa_sh[15:0] != 16'd0) begin
                                            gv_v   = 1'b1;
                                            gv_val = {16'd0, fa_sh[15:0]};
                                        end else begin
                                            st.vstage = 2'd2;
                                        end
                                    end
                                end else begin
                                    st.fa  = fa_sh;
                                    st.fbs = fbs_inc;
                                    if (fbs_inc >= 3'd4) begin
                                        st.fbs = 3'd0;
                                        gv_v   = 1'b1;
                                        gv_val = fa_sh;
                                    end
                                end
                                if (gv_v) begin
                                    st.vstage = 2'd0;
                                    st.fbs    = 3'd0;
                                    if (!cur_reg.vpc) begin
                                        st.lacc = cur_reg.lacc + gv_val;
                                        st.vpc  = 1'b1;
                                    end else begin
                                        st.pacc  = cur_reg.pacc + gv_val;
                                        st.vpc   = 1'b0;
                                        ev0_v    = 1'b1;
                                        ev0.kind = KIND_POINT;
                                        ev0.fidx = cur_reg.cfile;
                                        ev0.addr = st.pacc;
                                        ev0.line = cur_reg.lacc;
                                        st.eleft = cur_reg.eleft - 32'd1;
                                        if (st.eleft == 32'd0) st.phase = PH_TAIL;
                                    end
                                end
                            end
                            default: st.phase = cur_reg.phase;
                        endcase
                    end
                end
                default: st.phase = cur_reg.phase;
            endcase
        end
        pre = st;
        for (int i = 0; i < SettleSteps; i++) begin
            st = settle_once(st, flen_reg);
        end
        if (st.phase != PH_DONE && st.pos >= flen_reg) begin
            st.phase = PH_DONE;
            st.fstat = ST_EOF;
        end
        if (pre.phase != PH_DONE && st.phase == PH_DONE) begin
            ev1_v    = 1'b1;
            ev1.kind = KIND_STATUS;
            ev1.stat = st.fstat;
        end
        if (cur_reg.phase == PH_DONE) begin
            ev0_v = 1'b0;
            ev1_v = 1'b0;
            st    = cur_reg;
        end
        ev0.last = !ev1_v;
        ev1.last = 1'b1;
    end

    assign push_n = accept ? (2'(ev0_v) + 2'(ev1_v)) : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flen_reg   <= 32'd0;
            cur_reg    <= '{phase: PH_HDR, default: '0};
            rd_ptr_reg <= 2'd0;
            wr_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (cfg_wr_en) flen_reg <= cfg_wr_data;
            if (accept) cur_reg <= st;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 2'd1;
            wr_ptr_reg <= wr_ptr_reg + push_n;
            count_reg  <= count_reg + 3'(push_n) - 3'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (ev0_v) begin
                fifo_reg[wr_ptr_reg] <= ev0;
                if (ev1_v) fifo_reg[wr_ptr_reg + 2'd1] <= ev1;
            end else if (ev1_v) begin
                fifo_reg[wr_ptr_reg] <= ev1;
            end
        end
    end

    assign m_kind        = fifo_reg[rd_ptr_reg].kind;
    assign m_hunk_idx    = fifo_reg[rd_ptr_reg].fidx;
    assign m_name_char   = fifo_reg[rd_ptr_reg].ch;
    assign m_address     = fifo_reg[rd_ptr_reg].addr;
    assign m_line_number = fifo_reg[rd_ptr_reg].line;
    assign m_status      = fifo_reg[rd_ptr_reg].stat;
    assign m_last        = fifo_reg[rd_ptr_reg].last;

endmodule

/* sv/edltp_checker.sv */
// ----------------------------------------------------------------------------
// Debug line table parser checker
// Port level properties of the parser core, bound into the parser core module.
// ----------------------------------------------------------------------------
module edltp_checker
    import edltp_pkg::*;
#(
    parameter int FILE_INDEX_BITS = 16
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [1:0]                 m_kind,
    input logic [FILE_INDEX_BITS-1:0] m_hunk_idx,
    input logic [1:0]                 m_status,
    input logic                       m_last
);

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_NAME || m_kind == KIND_POINT || m_kind == KIND_STATUS))
        else $error("result beat has an undefined kind");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_STATUS) |-> m_last)
        else $error("status beat is not marked last");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_STATUS) |-> (m_status == ST_OK))
        else $error("non-status beat carries a status");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) && $stable(m_hunk_idx)))
        else $error("stalled result beat changed");

endmodule

bind exec_debug_line_table_parser_core edltp_checker #(
    .FILE_INDEX_BITS(FILE_INDEX_BITS)
) u_edltp_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_kind(m_kind),
    .m_hunk_idx(m_hunk_idx),
    .m_status(m_status),
    .m_last(m_last)
);
